// File: rtl/lcsg_pkg.sv
`timescale 1ns / 1ps

package lcsg_pkg;

  localparam int INIT_SEQUENCE_DEPTH = 64;
  // entries actually played by an init request
  localparam int SEQ_LEN      = 64;
  localparam int STEP_W       = $clog2(SEQ_LEN);
  localparam int QUEUE_DEPTH  = 2;
  localparam int NUM_REGS     = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_WINDOW    = 3'd1,
    OP_PIXEL     = 3'd2,
    OP_BACKLIGHT = 3'd3,
    OP_DEINIT    = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_CMD   = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_DELAY = 3'd2,
    KIND_RST   = 3'd3,
    KIND_BL    = 3'd4
  } item_kind_t;

  typedef enum logic [2:0] {
    REG_ORIENTATION  = 3'd0,
    REG_PIXEL_FORMAT = 3'd1,
    REG_VCOM         = 3'd2,
    REG_FRAME_RATE   = 3'd3,
    REG_RESET_PULSE  = 3'd4,
    REG_RESET_SETTLE = 3'd5,
    REG_DISPLAY_ON   = 3'd6
  } reg_index_t;

  localparam logic [7:0] RST_ORIENTATION  = 8'hA0;
  localparam logic [7:0] RST_PIXEL_FORMAT = 8'h55;
  localparam logic [7:0] RST_VCOM         = 8'h3F;
  localparam logic [7:0] RST_FRAME_RATE   = 8'h0F;
  localparam logic [7:0] RST_RESET_PULSE  = 8'd10;
  localparam logic [7:0] RST_RESET_SETTLE = 8'd120;
  localparam logic [7:0] RST_DISPLAY_ON   = 8'd100;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // where a ROM slot takes its value from
  typedef enum logic [2:0] {
    SRC_ROM, SRC_ORIENTATION, SRC_PIXEL_FORMAT, SRC_VCOM,
    SRC_FRAME_RATE, SRC_RESET_PULSE, SRC_RESET_SETTLE, SRC_DISPLAY_ON
  } slot_src_t;

  typedef enum logic [2:0] {
    JOB_INIT, JOB_WINDOW, JOB_PIXEL, JOB_BACKLIGHT, JOB_DEINIT
  } job_kind_t;

  // back-end sequencer state
  typedef enum logic {BK_IDLE, BK_RUN} bk_state_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] pixel_color;
    logic        backlight_on;
  } job_t;

  typedef struct packed {
    logic [7:0] orientation;
    logic [7:0] pixel_format;
    logic [7:0] vcom;
    logic [7:0] frame_rate;
    logic [7:0] reset_pulse;
    logic [7:0] reset_settle;
    logic [7:0] display_on_wait;
  } cfg_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] value;
  } rom_entry_t;

  function automatic rom_entry_t rom_entry(int idx);
    rom_entry_t e;
    case (idx)
      0:  e = '{KIND_RST, 8'h01};
      1:  e = '{KIND_BL, 8'h00};
      2:  e = '{KIND_RST, 8'h00};
      3:  e = '{KIND_DELAY, 8'h00};
      4:  e = '{KIND_RST, 8'h01};
      5:  e = '{KIND_DELAY, 8'h00};
      6:  e = '{KIND_CMD, 8'h11};
      7:  e = '{KIND_DELAY, 8'h00};
      8:  e = '{KIND_CMD, 8'h3A};
      9:  e = '{KIND_DATA, 8'h00};
      10: e = '{KIND_CMD, 8'h36};
      11: e = '{KIND_DATA, 8'h00};
      12: e = '{KIND_CMD, 8'hB2};
      13: e = '{KIND_DATA, 8'h0C};
      14: e = '{KIND_DATA, 8'h0C};
      15: e = '{KIND_DATA, 8'h00};
      16: e = '{KIND_DATA, 8'h33};
      17: e = '{KIND_DATA, 8'h33};
      18: e = '{KIND_CMD, 8'hB7};
      19: e = '{KIND_DATA, 8'h35};
      20: e = '{KIND_CMD, 8'hBB};
      21: e = '{KIND_DATA, 8'h00};
      22: e = '{KIND_CMD, 8'hC0};
      23: e = '{KIND_DATA, 8'h2C};
      24: e = '{KIND_CMD, 8'hC2};
      25: e = '{KIND_DATA, 8'h01};
      26: e = '{KIND_CMD, 8'hC3};
      27: e = '{KIND_DATA, 8'h11};
      28: e = '{KIND_CMD, 8'hC4};
      29: e = '{KIND_DATA, 8'h20};
      30: e = '{KIND_CMD, 8'hC6};
      31: e = '{KIND_DATA, 8'h00};
      32: e = '{KIND_CMD, 8'hE0};
      33: e = '{KIND_DATA, 8'hD0};
      34: e = '{KIND_DATA, 8'h08};
      35: e = '{KIND_DATA, 8'h11};
      36: e = '{KIND_DATA, 8'h08};
      37: e = '{KIND_DATA, 8'h0C};
      38: e = '{KIND_DATA, 8'h15};
      39: e = '{KIND_DATA, 8'h39};
      40: e = '{KIND_DATA, 8'h33};
      41: e = '{KIND_DATA, 8'h50};
      42: e = '{KIND_DATA, 8'h36};
      43: e = '{KIND_DATA, 8'h13};
      44: e = '{KIND_DATA, 8'h14};
      45: e = '{KIND_DATA, 8'h29};
      46: e = '{KIND_DATA, 8'h2D};
      47: e = '{KIND_CMD, 8'hE1};
      48: e = '{KIND_DATA, 8'hD0};
      49: e = '{KIND_DATA, 8'h08};
      50: e = '{KIND_DATA, 8'h10};
      51: e = '{KIND_DATA, 8'h08};
      52: e = '{KIND_DATA, 8'h06};
      53: e = '{KIND_DATA, 8'h06};
      54: e = '{KIND_DATA, 8'h39};
      55: e = '{KIND_DATA, 8'h44};
      56: e = '{KIND_DATA, 8'h51};
      57: e = '{KIND_DATA, 8'h0B};
      58: e = '{KIND_DATA, 8'h16};
      59: e = '{KIND_DATA, 8'h14};
      60: e = '{KIND_DATA, 8'h2F};
      61: e = '{KIND_DATA, 8'h31};
      62: e = '{KIND_CMD, 8'h29};
      63: e = '{KIND_DELAY, 8'h00};
      default: e = '{KIND_CMD, 8'h00};
    endcase
    return e;
  endfunction

  function automatic slot_src_t slot_src(int idx);
    slot_src_t s;
    case (idx)
      3:       s = SRC_RESET_PULSE;
      5:       s = SRC_RESET_SETTLE;
      7:       s = SRC_RESET_SETTLE;
      9:       s = SRC_PIXEL_FORMAT;
      11:      s = SRC_ORIENTATION;
      21:      s = SRC_VCOM;
      31:      s = SRC_FRAME_RATE;
      63:      s = SRC_DISPLAY_ON;
      default: s = SRC_ROM;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/lcsg_if.sv
`timescale 1ns / 1ps

interface lcsg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] x_end;
  logic [15:0] y_end;
  logic [15:0] pixel_color;
  logic        backlight_on;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, pixel_color,
                  backlight_on, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, pixel_color,
                  backlight_on, output ready);
endinterface

interface lcsg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] item_kind;
  logic [7:0] item_value;
  logic       last_of_run;

  modport source (output valid, item_kind, item_value, last_of_run, input ready);
  modport sink   (input valid, item_kind, item_value, last_of_run, output ready);
endinterface

// File: rtl/lcsg_front.sv
`timescale 1ns / 1ps

module lcsg_front (
  input  logic             clk,
  input  logic             rst_n,
  lcsg_in_if.sink          in_bus,
  input  logic             q_ready,
  output logic             q_push,
  output lcsg_pkg::job_t   q_job
);

  logic initialized_r, initialized_nxt;
  logic accept;
  logic keep;

  assign in_bus.ready = q_ready;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    q_job.x_start      = in_bus.x_start;
    q_job.y_start      = in_bus.y_start;
    q_job.x_end        = in_bus.x_end;
    q_job.y_end        = in_bus.y_end;
    q_job.pixel_color  = in_bus.pixel_color;
    q_job.backlight_on = in_bus.backlight_on;
    q_job.kind         = lcsg_pkg::JOB_BACKLIGHT;
    keep               = 1'b0;
    initialized_nxt    = initialized_r;
    case (in_bus.opcode)
      lcsg_pkg::OP_INIT: begin
        q_job.kind = lcsg_pkg::JOB_INIT;
        keep       = !initialized_r;
        if (accept) initialized_nxt = 1'b1;
      end
      lcsg_pkg::OP_WINDOW: begin
        q_job.kind = lcsg_pkg::JOB_WINDOW;
        keep       = 1'b1;
      end
      lcsg_pkg::OP_PIXEL: begin
        q_job.kind = lcsg_pkg::JOB_PIXEL;
        keep       = 1'b1;
      end
      lcsg_pkg::OP_BACKLIGHT: begin
        q_job.kind = lcsg_pkg::JOB_BACKLIGHT;
        keep       = 1'b1;
      end
      lcsg_pkg::OP_DEINIT: begin
        q_job.kind = lcsg_pkg::JOB_DEINIT;
        keep       = initialized_r;
        if (accept) initialized_nxt = 1'b0;
      end
      default: keep = 1'b0;  // unused opcodes dropped
    endcase
  end

  assign q_push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initialized_r <= 1'b0;
    end else begin
      initialized_r <= initialized_nxt;
    end
  end

endmodule

// File: rtl/lcsg_queue.sv
`timescale 1ns / 1ps

module lcsg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcsg_pkg::job_t   push_job,
  output logic             ready,
  input  logic             pop,
  output logic             head_valid,
  output lcsg_pkg::job_t   head_job
);

  localparam int PTR_W = $clog2(lcsg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lcsg_pkg::QUEUE_DEPTH + 1);

  lcsg_pkg::job_t    slot_r [lcsg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign ready      = (count_r != CNT_W'(lcsg_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(lcsg_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/lcsg_back.sv
`timescale 1ns / 1ps

module lcsg_back #(
  parameter int INIT_SEQUENCE_DEPTH = lcsg_pkg::INIT_SEQUENCE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lcsg_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  lcsg_pkg::job_t   q_head,
  output logic             q_pop,
  lcsg_out_if.source       out_bus
);

  localparam int ROM_AW = $clog2(INIT_SEQUENCE_DEPTH);
  localparam int STEP_W = lcsg_pkg::STEP_W;

  lcsg_pkg::bk_state_t      state_r, state_nxt;
  lcsg_pkg::job_t           job_r, job_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  lcsg_pkg::item_kind_t     out_kind_r, out_kind_nxt;
  logic [7:0]               out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;

  lcsg_pkg::job_t           cur_job;
  logic                     cur_ok;
  logic [STEP_W-1:0]        step;
  logic [ROM_AW-1:0]        rom_addr;
  lcsg_pkg::rom_entry_t     rom_e;
  lcsg_pkg::slot_src_t      src;
  lcsg_pkg::item_kind_t     it_kind;
  logic [7:0]               it_value;
  logic                     it_last;
  logic                     out_free;
  logic                     fire;

  // first item of a job is taken straight from the queue head
  assign cur_ok   = (state_r == lcsg_pkg::BK_RUN) || q_valid;
  assign cur_job  = (state_r == lcsg_pkg::BK_RUN) ? job_r : q_head;
  assign step     = (state_r == lcsg_pkg::BK_RUN) ? step_r : '0;
  assign rom_addr = ROM_AW'(step);
  assign rom_e    = lcsg_pkg::rom_entry(int'(rom_addr));
  assign src      = lcsg_pkg::slot_src(int'(rom_addr));

  always_comb begin
    it_kind  = lcsg_pkg::KIND_DATA;
    it_value = 8'h00;
    it_last  = 1'b1;
    case (cur_job.kind)
      lcsg_pkg::JOB_INIT: begin
        it_kind = rom_e.kind;
        it_last = (step == STEP_W'(lcsg_pkg::SEQ_LEN - 1));
        case (src)
          lcsg_pkg::SRC_ORIENTATION:  it_value = cfg.orientation;
          lcsg_pkg::SRC_PIXEL_FORMAT: it_value = cfg.pixel_format;
          lcsg_pkg::SRC_VCOM:         it_value = cfg.vcom;
          lcsg_pkg::SRC_FRAME_RATE:   it_value = cfg.frame_rate;
          lcsg_pkg::SRC_RESET_PULSE:  it_value = cfg.reset_pulse;
          lcsg_pkg::SRC_RESET_SETTLE: it_value = cfg.reset_settle;
          lcsg_pkg::SRC_DISPLAY_ON:   it_value = cfg.display_on_wait;
          default:                    it_value = rom_e.value;
        endcase
      end
      lcsg_pkg::JOB_WINDOW: begin
        it_last = 1'b0;
        case (step)
          STEP_W'(0): begin
            it_kind  = lcsg_pkg::KIND_CMD;
            it_value = lcsg_pkg::CMD_CASET;
          end
          STEP_W'(1): it_value = cur_job.x_start[15:8];
          STEP_W'(2): it_value = cur_job.x_start[7:0];
          STEP_W'(3): it_value = cur_job.x_end[15:8];
          STEP_W'(4): it_value = cur_job.x_end[7:0];
          STEP_W'(5): begin
            it_kind  = lcsg_pkg::KIND_CMD;
            it_value = lcsg_pkg::CMD_RASET;
          end
          STEP_W'(6): it_value = cur_job.y_start[15:8];
          STEP_W'(7): it_value = cur_job.y_start[7:0];
          STEP_W'(8): it_value = cur_job.y_end[15:8];
          STEP_W'(9): it_value = cur_job.y_end[7:0];
          default: begin
            it_kind  = lcsg_pkg::KIND_CMD;
            it_value = lcsg_pkg::CMD_RAMWR;
            it_last  = 1'b1;
          end
        endcase
      end
      lcsg_pkg::JOB_PIXEL: begin
        it_last  = (step != '0);
        it_value = (step == '0) ? cur_job.pixel_color[15:8] : cur_job.pixel_color[7:0];
      end
      lcsg_pkg::JOB_BACKLIGHT: begin
        it_kind  = lcsg_pkg::KIND_BL;
        it_value = {7'd0, cur_job.backlight_on};
      end
      default: begin  // deinit
        it_kind  = lcsg_pkg::KIND_BL;
        it_value = 8'h00;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_bus.ready;
  assign fire     = cur_ok && out_free;
  assign q_pop    = fire && (state_r == lcsg_pkg::BK_IDLE);

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (out_bus.ready) out_valid_nxt = 1'b0;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = it_kind;
      out_value_nxt = it_value;
      out_last_nxt  = it_last;
      job_nxt       = cur_job;
      step_nxt      = step + 1'b1;
      state_nxt     = it_last ? lcsg_pkg::BK_IDLE : lcsg_pkg::BK_RUN;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    step_r      <= step_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcsg_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.item_kind   = out_kind_r;
  assign out_bus.item_value  = out_value_r;
  assign out_bus.last_of_run = out_last_r;

`ifndef NO_ASSERTIONS
  a_run_past_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcsg_pkg::BK_RUN |-> step_r != '0)
    else $error("sequencer running at step zero");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcsg_pkg::BK_RUN && job_r.kind == lcsg_pkg::JOB_WINDOW
      |-> step_r <= STEP_W'(10))
    else $error("window run overran its 11 beats");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    fire && it_last |=> state_r == lcsg_pkg::BK_IDLE && out_last_r)
    else $error("run did not end after its last beat");
`endif

endmodule

// File: rtl/lcd_command_stream_generator_top.sv
`timescale 1ns / 1ps
// A 2-entry job queue parts intake from playback. Each kept request enters it, and
// its first result beat is registered onto out_bus from the queue head. Throughput:
// one result beat per cycle while out_bus.ready is high; a pixel makes 2 beats, a
// window 11, an init 64, backlight and deinit 1. Beatless requests wait for queue room.
// Reset: synchronous, active-low rst_n; clears queue, sequencer, output valid and the
// initialized flag, and reloads the configuration registers with their defaults.

module lcd_command_stream_generator_top #(
  parameter int INIT_SEQUENCE_DEPTH = lcsg_pkg::INIT_SEQUENCE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lcsg_in_if.sink                         in_bus,
  lcsg_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [lcsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcsg_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration bank. The user writes it only while the block is idle, so the
  // sequencer may read it live while playing the init ROM; the block does not check it.
  lcsg_pkg::cfg_t cfg_r, cfg_nxt;

  // front -> queue -> back
  logic           q_push;
  lcsg_pkg::job_t q_push_job;
  logic           q_ready;
  logic           q_pop;
  logic           q_valid;
  lcsg_pkg::job_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lcsg_pkg::REG_ORIENTATION:  cfg_nxt.orientation     = cfg_data;
        lcsg_pkg::REG_PIXEL_FORMAT: cfg_nxt.pixel_format    = cfg_data;
        lcsg_pkg::REG_VCOM:         cfg_nxt.vcom            = cfg_data;
        lcsg_pkg::REG_FRAME_RATE:   cfg_nxt.frame_rate      = cfg_data;
        lcsg_pkg::REG_RESET_PULSE:  cfg_nxt.reset_pulse     = cfg_data;
        lcsg_pkg::REG_RESET_SETTLE: cfg_nxt.reset_settle    = cfg_data;
        lcsg_pkg::REG_DISPLAY_ON:   cfg_nxt.display_on_wait = cfg_data;
        default:                    cfg_nxt = cfg_r;  // index past the bank: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.orientation     <= lcsg_pkg::RST_ORIENTATION;
      cfg_r.pixel_format    <= lcsg_pkg::RST_PIXEL_FORMAT;
      cfg_r.vcom            <= lcsg_pkg::RST_VCOM;
      cfg_r.frame_rate      <= lcsg_pkg::RST_FRAME_RATE;
      cfg_r.reset_pulse     <= lcsg_pkg::RST_RESET_PULSE;
      cfg_r.reset_settle    <= lcsg_pkg::RST_RESET_SETTLE;
      cfg_r.display_on_wait <= lcsg_pkg::RST_DISPLAY_ON;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: takes a request beat, drops ignored ones (init when up,
  // deinit when down, unused opcodes) and tracks the initialized flag.
  lcsg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_ready(q_ready),
    .q_push (q_push),
    .q_job  (q_push_job)
  );

  lcsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .ready     (q_ready),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_job  (q_head)
  );

  // Back end: steps through each job into the output register, one result beat per
  // cycle while out_bus.ready holds; the first beat comes straight off the queue head.
  lcsg_back #(
    .INIT_SEQUENCE_DEPTH(INIT_SEQUENCE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_bus(out_bus)
  );

endmodule

// File: dv/lcd_command_stream_generator_top_tb.sv
`timescale 1ns / 1ps

// Request-level check of the LCD command stream generator.
// Requests go in on in_bus and the byte/delay/line beats come out on out_bus.
// A shadow of the initialized flag and of the seven registers sits in this
// module. Every accepted request is expanded into the beats it should produce.
// Those beats queue up and are matched in order against what the block emits.
module lcd_command_stream_generator_top_tb;
  import lcsg_pkg::*;

  // opcodes the block has no use for; requests carrying them are dropped
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  // register index past the last register; writes to it are dropped
  localparam logic [2:0] REG_SPARE = 3'd7;

  localparam int IDLE_PCT      = 22;    // per side, chance of a dead cycle
  localparam int PHASE_REQS    = 115;   // requests that make beats, per phase
  localparam int SETTLE_CYCLES = 16;    // wait after the owed beats drain
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all

  // Init sequence bytes in playback order. Slots that take a register value
  // hold zero here and are patched in when the init is expanded.
  localparam logic [0:63][7:0] INIT_BYTES = {
    8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h11, 8'h00,
    8'h3A, 8'h00, 8'h36, 8'h00, 8'hB2, 8'h0C, 8'h0C, 8'h00,
    8'h33, 8'h33, 8'hB7, 8'h35, 8'hBB, 8'h00, 8'hC0, 8'h2C,
    8'hC2, 8'h01, 8'hC3, 8'h11, 8'hC4, 8'h20, 8'hC6, 8'h00,
    8'hE0, 8'hD0, 8'h08, 8'h11, 8'h08, 8'h0C, 8'h15, 8'h39,
    8'h33, 8'h50, 8'h36, 8'h13, 8'h14, 8'h29, 8'h2D, 8'hE1,
    8'hD0, 8'h08, 8'h10, 8'h08, 8'h06, 8'h06, 8'h39, 8'h44,
    8'h51, 8'h0B, 8'h16, 8'h14, 8'h2F, 8'h31, 8'h29, 8'h00
  };

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] xs;
    logic [15:0] ys;
    logic [15:0] xe;
    logic [15:0] ye;
    logic [15:0] color;
    logic        bl;
  } lcd_req_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] value;
    logic       last;
  } lcd_beat_t;

  // One request plus, where the answer is obvious, the beats it must make.
  // n_fixed < 0 leaves the answer to the shadow model.
  typedef struct packed {
    lcd_req_t  req;
    int        n_fixed;
    lcd_beat_t b0;
    lcd_beat_t b1;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lcsg_in_if  in_bus ();
  lcsg_out_if out_bus ();

  lcd_command_stream_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow state of the block
  logic       panel_on;
  logic [7:0] reg_shadow [NUM_REGS];

  lcd_beat_t  fresh_beats [$];   // beats of the request just taken
  lcd_beat_t  lcd_stream_q [$];  // beats still owed by the block
  stim_row_t  live_row;          // row currently offered on in_bus
  stim_row_t  dir_table [$];

  int  fail_cnt;
  int  useful_reqs;              // accepted requests that made beats
  int  quiet_cycles;
  bit  steady;                   // no dead cycles on either side while set

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  task automatic add_beat(input item_kind_t kind, input logic [7:0] value);
    lcd_beat_t b;
    b.kind  = kind;
    b.value = value;
    b.last  = 1'b0;
    fresh_beats.push_back(b);
  endtask

  // coordinates and colors go out big-endian
  task automatic add_word(input logic [15:0] w);
    add_beat(KIND_DATA, w[15:8]);
    add_beat(KIND_DATA, w[7:0]);
  endtask

  task automatic expand_request(input lcd_req_t r);
    int         i;
    item_kind_t k;
    logic [7:0] v;
    fresh_beats.delete();
    case (r.op)
      OP_INIT: begin
        // a second init while the panel is up is dropped
        if (!panel_on) begin
          for (i = 0; i < 64; i++) begin
            v = INIT_BYTES[i];
            case (i)
              0, 2, 4:     k = KIND_RST;
              1:           k = KIND_BL;
              3, 5, 7, 63: k = KIND_DELAY;
              6, 8, 10, 12, 18, 20, 22, 24, 26, 28, 30, 32, 47, 62:
                           k = KIND_CMD;
              default:     k = KIND_DATA;
            endcase
            // register-sourced slots: delays, format, orientation, VCOM, frame rate
            case (i)
              3:    v = reg_shadow[REG_RESET_PULSE];
              5, 7: v = reg_shadow[REG_RESET_SETTLE];
              9:    v = reg_shadow[REG_PIXEL_FORMAT];
              11:   v = reg_shadow[REG_ORIENTATION];
              21:   v = reg_shadow[REG_VCOM];
              31:   v = reg_shadow[REG_FRAME_RATE];
              63:   v = reg_shadow[REG_DISPLAY_ON];
              default: ;
            endcase
            add_beat(k, v);
          end
          panel_on = 1'b1;
        end
      end
      OP_WINDOW: begin
        // bounds go out as given, no ordering check
        add_beat(KIND_CMD, CMD_CASET);
        add_word(r.xs);
        add_word(r.xe);
        add_beat(KIND_CMD, CMD_RASET);
        add_word(r.ys);
        add_word(r.ye);
        add_beat(KIND_CMD, CMD_RAMWR);
      end
      OP_PIXEL:     add_word(r.color);
      OP_BACKLIGHT: add_beat(KIND_BL, {7'd0, r.bl});
      OP_DEINIT: begin
        if (panel_on) begin
          add_beat(KIND_BL, 8'h00);
          panel_on = 1'b0;
        end
      end
      default: ;
    endcase
    if (fresh_beats.size() > 0)
      fresh_beats[fresh_beats.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: config writes, request intake, beat checking, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    lcd_req_t  r;
    lcd_beat_t b;
    bit        moved;
    int        i;
    if (rst_n) begin
      moved = 1'b0;

      if (cfg_we) begin
        if (cfg_index < NUM_REGS)
          reg_shadow[cfg_index] = cfg_data;
        moved = 1'b1;
      end

      if (in_bus.valid && in_bus.ready) begin
        r.op    = in_bus.opcode;
        r.xs    = in_bus.x_start;
        r.ys    = in_bus.y_start;
        r.xe    = in_bus.x_end;
        r.ye    = in_bus.y_end;
        r.color = in_bus.pixel_color;
        r.bl    = in_bus.backlight_on;
        // the model always runs so that the initialized flag tracks the block
        expand_request(r);
        if (fresh_beats.size() > 0)
          useful_reqs++;
        if (live_row.n_fixed < 0) begin
          foreach (fresh_beats[i])
            lcd_stream_q.push_back(fresh_beats[i]);
        end else begin
          // typed-in answer for this row takes the place of the model's
          for (i = 0; i < live_row.n_fixed; i++) begin
            b = (i == 0) ? live_row.b0 : live_row.b1;
            b.last = (i == live_row.n_fixed - 1);
            lcd_stream_q.push_back(b);
          end
        end
        moved = 1'b1;
      end

      if (out_bus.valid && out_bus.ready) begin
        if (lcd_stream_q.size() == 0) begin
          $error("stray beat: item_kind %0d item_value 0x%02h last_of_run %0b",
                 out_bus.item_kind, out_bus.item_value, out_bus.last_of_run);
          fail_cnt++;
        end else begin
          b = lcd_stream_q.pop_front();
          if (out_bus.item_kind !== b.kind) begin
            $error("item_kind: expected %0d, got %0d", b.kind, out_bus.item_kind);
            fail_cnt++;
          end
          if (out_bus.item_value !== b.value) begin
            $error("item_value: expected 0x%02h, got 0x%02h", b.value, out_bus.item_value);
            fail_cnt++;
          end
          if (out_bus.last_of_run !== b.last) begin
            $error("last_of_run: expected %0b, got %0b", b.last, out_bus.last_of_run);
            fail_cnt++;
          end
        end
        moved = 1'b1;
      end

      // a hang shows up as a long run of cycles with no handshake anywhere
      if (moved)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // sink side: random back-pressure, none while steady
  always @(negedge clk)
    out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t mk_row(input logic [2:0] op, input logic [15:0] xs,
                                       input logic [15:0] ys, input logic [15:0] xe,
                                       input logic [15:0] ye, input logic [15:0] color,
                                       input logic bl, input int n,
                                       input item_kind_t k0, input logic [7:0] v0,
                                       input item_kind_t k1, input logic [7:0] v1);
    stim_row_t s;
    s.req.op    = op;
    s.req.xs    = xs;
    s.req.ys    = ys;
    s.req.xe    = xe;
    s.req.ye    = ye;
    s.req.color = color;
    s.req.bl    = bl;
    s.n_fixed   = n;
    s.b0.kind   = k0;
    s.b0.value  = v0;
    s.b0.last   = 1'b0;
    s.b1.kind   = k1;
    s.b1.value  = v1;
    s.b1.last   = 1'b0;
    return s;
  endfunction

  function automatic stim_row_t rand_row(input logic [2:0] op);
    return mk_row(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom), -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00);
  endfunction

  // Offer one request and return on the falling edge after it was taken.
  // valid is left high; whatever comes next must drive it.
  task automatic send_req(input stim_row_t s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    live_row = s;
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= s.req.op;
    in_bus.x_start      <= s.req.xs;
    in_bus.y_start      <= s.req.ys;
    in_bus.x_end        <= s.req.xe;
    in_bus.y_end        <= s.req.ye;
    in_bus.pixel_color  <= s.req.color;
    in_bus.backlight_on <= s.req.bl;
    @(posedge clk);
    while (!in_bus.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, let every owed beat drain, then give requests that make no
  // beat time to clear the pipe.
  task automatic drain_all();
    in_bus.valid <= 1'b0;
    while (lcd_stream_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // registers only change with the block idle
  task automatic load_settings(input logic [7:0] orient, input logic [7:0] fmt,
                               input logic [7:0] vcom, input logic [7:0] frate,
                               input logic [7:0] pulse, input logic [7:0] settle,
                               input logic [7:0] on_wait);
    drain_all();
    write_reg(REG_ORIENTATION,  orient);
    write_reg(REG_PIXEL_FORMAT, fmt);
    write_reg(REG_VCOM,         vcom);
    write_reg(REG_FRAME_RATE,   frate);
    write_reg(REG_RESET_PULSE,  pulse);
    write_reg(REG_RESET_SETTLE, settle);
    write_reg(REG_DISPLAY_ON,   on_wait);
    write_reg(REG_SPARE,        8'($urandom));  // must not land anywhere
    cfg_we <= 1'b0;
  endtask

  // Mostly a well-formed drawing pass: init if needed, a window, a handful of
  // pixels, sometimes backlight or deinit. The rest is noise over all opcodes.
  task automatic random_session();
    int npix;
    if ($urandom_range(99) < 20) begin
      send_req(rand_row(3'($urandom)));
    end else begin
      if (!panel_on && $urandom_range(99) < 85)
        send_req(rand_row(OP_INIT));
      send_req(rand_row(OP_WINDOW));
      npix = $urandom_range(8, 1);
      repeat (npix) send_req(rand_row(OP_PIXEL));
      if ($urandom_range(99) < 15)
        send_req(rand_row(OP_BACKLIGHT));
      if ($urandom_range(99) < 10)
        send_req(rand_row(OP_DEINIT));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stim
    int ph;
    int target;

    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_bus.valid = 1'b0;
    in_bus.opcode       = OP_INIT;
    in_bus.x_start      = '0;
    in_bus.y_start      = '0;
    in_bus.x_end        = '0;
    in_bus.y_end        = '0;
    in_bus.pixel_color  = '0;
    in_bus.backlight_on = 1'b0;
    out_bus.ready = 1'b0;
    fail_cnt      = 0;
    useful_reqs   = 0;
    quiet_cycles  = 0;
    steady        = 1'b0;
    panel_on      = 1'b0;
    live_row      = rand_row(OP_INIT);
    reg_shadow[REG_ORIENTATION]  = RST_ORIENTATION;
    reg_shadow[REG_PIXEL_FORMAT] = RST_PIXEL_FORMAT;
    reg_shadow[REG_VCOM]         = RST_VCOM;
    reg_shadow[REG_FRAME_RATE]   = RST_FRAME_RATE;
    reg_shadow[REG_RESET_PULSE]  = RST_RESET_PULSE;
    reg_shadow[REG_RESET_SETTLE] = RST_RESET_SETTLE;
    reg_shadow[REG_DISPLAY_ON]   = RST_DISPLAY_ON;

    // Directed table, run on the reset defaults. Rows with a beat count carry
    // their answer; -1 rows go through the shadow model.
    // backlight works in any state; deinit before init says nothing
    dir_table.push_back(mk_row(OP_BACKLIGHT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b1, 1, KIND_BL, 8'h01, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_BACKLIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 1'b0, 1, KIND_BL, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_DEINIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 1'b1, 0, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    // pixel color extremes, sent before any init
    dir_table.push_back(mk_row(OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'h0000, 1'b1, 2, KIND_DATA, 8'h00, KIND_DATA, 8'h00));
    dir_table.push_back(mk_row(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'hFFFF, 1'b0, 2, KIND_DATA, 8'hFF, KIND_DATA, 8'hFF));
    // windows: all zero, all ones, bounds reversed
    dir_table.push_back(mk_row(OP_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b0, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 1'b1, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_WINDOW, 16'h1234, 16'hABCD, 16'h0010, 16'h0001,
                               16'h5A5A, 1'b0, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    // unused opcodes are dropped
    dir_table.push_back(mk_row(OP_SPARE5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 1'b1, 0, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_SPARE6, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b0, 0, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_SPARE7, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                               16'hFFFF, 1'b1, 0, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    // init, then a repeat init that must be dropped
    dir_table.push_back(mk_row(OP_INIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b0, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_INIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 1'b1, 0, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_WINDOW, 16'h0000, 16'h0000, 16'h013F, 16'h00EF,
                               16'h0000, 1'b0, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'hA55A, 1'b0, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_BACKLIGHT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b1, 1, KIND_BL, 8'h01, KIND_CMD, 8'h00));
    // deinit while up turns the backlight off; a second deinit is dropped
    dir_table.push_back(mk_row(OP_DEINIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b1, 1, KIND_BL, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_DEINIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b0, 0, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h8001, 1'b0, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    // re-init after deinit plays the whole sequence again
    dir_table.push_back(mk_row(OP_INIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b0, -1, KIND_CMD, 8'h00, KIND_CMD, 8'h00));
    dir_table.push_back(mk_row(OP_DEINIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b0, 1, KIND_BL, 8'h00, KIND_CMD, 8'h00));

    // reset held from time zero, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i])
      send_req(dir_table[i]);

    // Random phases, each behind a full drain and a new register set:
    // all ones, all zeros (zero delays still go out), then two random sets.
    // The all-zero phase runs without any dead cycles on either side.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1: load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        default: load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      steady = (ph == 1);
      // drop out of the initialized state so the new settings get played
      send_req(rand_row(OP_DEINIT));
      target = useful_reqs + PHASE_REQS;
      while (useful_reqs < target)
        random_session();
    end
    steady = 1'b0;

    drain_all();
    if (fail_cnt == 0 && lcd_stream_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lcsg_pkg.sv
rtl/lcsg_if.sv
rtl/lcsg_front.sv
rtl/lcsg_queue.sv
rtl/lcsg_back.sv
rtl/lcd_command_stream_generator_top.sv
dv/lcd_command_stream_generator_top_tb.sv
